### design/swa_pkg.sv
package swa_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS = 16;
  localparam int SUM_BITS    = 24;
  localparam int AVG_BITS    = 16;
  localparam int LEN_BITS    = 9;

  // window length after reset
  localparam logic [LEN_BITS-1:0] WINDOW_LEN_RESET = 9'd4;

  // input word
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [AVG_BITS-1:0] average;
    logic signed [SUM_BITS-1:0] window_sum;
    logic                       end_of_sequence;
  } out_word_t;

  // job handed from the sum stage to the divider
  typedef struct packed {
    logic signed [SUM_BITS-1:0] window_sum;
    logic                       last;
  } div_job_t;

endpackage

### design/swa_ram.sv
module swa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/swa_div.sv
module swa_div #(
  parameter int DIV_BITS = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  swa_pkg::div_job_t    job,
  input  logic [DIV_BITS-1:0]  divisor,
  output logic                 res_valid,
  input  logic                 res_ready,
  output swa_pkg::out_word_t   res
);

  localparam int SW   = swa_pkg::SUM_BITS;
  localparam int CNTW = $clog2(SW);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIX,
    D_DONE
  } dstate_t;

  dstate_t             state_r, state_nxt;
  logic [SW-1:0]       quo_r, quo_nxt;
  logic [DIV_BITS:0]   rem_r, rem_nxt;
  logic [DIV_BITS-1:0] div_r, div_nxt;
  logic [CNTW-1:0]     cnt_r, cnt_nxt;
  logic                neg_r, neg_nxt;
  logic [SW-1:0]       sum_r, sum_nxt;
  logic                last_r, last_nxt;

  logic [DIV_BITS:0]   rem_sh;
  logic                ge;
  logic [SW-1:0]       mag;

  assign job_ready = (state_r == D_IDLE);
  assign res_valid = (state_r == D_DONE);
  assign res.average         = quo_r[swa_pkg::AVG_BITS-1:0];
  assign res.window_sum      = sum_r;
  assign res.end_of_sequence = last_r;

  // magnitude of the dividend
  assign mag = job.window_sum[SW-1] ? (~job.window_sum + 1'b1) : job.window_sum;

  // one restoring step per cycle
  assign rem_sh = {rem_r[DIV_BITS-1:0], quo_r[SW-1]};
  assign ge     = (rem_sh >= {1'b0, div_r});

  always_comb begin
    state_nxt = state_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    sum_nxt   = sum_r;
    last_nxt  = last_r;
    case (state_r)
      D_IDLE: begin
        if (job_valid) begin
          quo_nxt   = mag;
          rem_nxt   = '0;
          div_nxt   = divisor;
          cnt_nxt   = '0;
          neg_nxt   = job.window_sum[SW-1];
          sum_nxt   = job.window_sum;
          last_nxt  = job.last;
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        rem_nxt = ge ? (rem_sh - {1'b0, div_r}) : rem_sh;
        quo_nxt = {quo_r[SW-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(SW - 1)) begin
          state_nxt = D_FIX;
        end
      end
      D_FIX: begin
        // truncation toward zero: negate the magnitude quotient
        if (neg_r) begin
          quo_nxt = ~quo_r + 1'b1;
        end
        state_nxt = D_DONE;
      end
      D_DONE: begin
        if (res_ready) begin
          state_nxt = D_IDLE;
        end
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    sum_r  <= sum_nxt;
    last_r <= last_nxt;
  end

endmodule

### design/sliding_window_average_core.sv
// Moving average over sequences of signed samples.
// Input channel in_valid/in_ready carries one word (sample, last flag) per
// handshake; the result channel out_valid/out_ready carries (average,
// window_sum, end_of_sequence). Once window_len samples of a sequence have
// arrived, each sample gives one result word; earlier samples give none.
// A word flagged last closes the sequence and clears the running sum.
// cfg_we/cfg_wdata write window_len; the user must do so only while the block
// is idle, which the block does not enforce. In the sum stage the delay-line
// memory is written and the oldest sample read at acceptance, and the sum is
// updated in ST_SUM, which holds until the divider takes any result-producing
// word; no new word is accepted meanwhile. The bit-serial divider loads a job,
// finds one quotient bit per cycle over the 24-bit sum, fixes the sign and
// hands off, taking no new job until then. The divider is the rate limit.
// A finished result sits in an output register; a stalled receiver backs up
// into the divider and then the sum stage, with no word lost.
// Reset clears the sum, fill count, write slot and sets window_len to 4; the
// delay-line memory is not cleared, entries are written before they are read.
module sliding_window_average_core #(
  parameter int WINDOW_MAX = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  swa_pkg::in_word_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output swa_pkg::out_word_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [swa_pkg::LEN_BITS-1:0]         cfg_wdata
);

  localparam int SB = swa_pkg::SAMPLE_BITS;
  localparam int SW = swa_pkg::SUM_BITS;
  localparam int AW = $clog2(WINDOW_MAX);
  localparam int FW = $clog2(WINDOW_MAX + 1);
  localparam int KW = (FW > swa_pkg::LEN_BITS) ? FW : swa_pkg::LEN_BITS;

  typedef enum logic {
    ST_IDLE,
    ST_SUM
  } state_t;

  state_t                       state_r, state_nxt;
  logic [swa_pkg::LEN_BITS-1:0] len_r;
  logic [SW-1:0]                run_r, run_nxt;
  logic [FW-1:0]                fill_r, fill_nxt;
  logic [AW-1:0]                slot_r, slot_nxt;
  logic signed [SB-1:0]         s_r;
  logic                         last_r;
  logic                         emit_r;

  logic [KW-1:0]                len_x;
  logic [KW-1:0]                k_eff;
  logic [KW-1:0]                km1;
  logic [AW:0]                  diff;
  logic [AW:0]                  diff_wrap;
  logic [AW-1:0]                oldest;
  logic [FW-1:0]                fill_inc;
  logic                         accept;
  logic [SB-1:0]                rd_data;
  logic [SB-1:0]                old_s;
  logic [SW-1:0]                sum_w;

  logic                         job_valid, job_ready;
  swa_pkg::div_job_t            job;
  logic                         res_valid, res_ready;
  swa_pkg::out_word_t           res;

  // effective window length: zero acts as one, clamp at the maximum
  assign len_x = KW'(len_r);
  always_comb begin
    k_eff = len_x;
    if (len_x == '0) begin
      k_eff = KW'(1);
    end else if (len_x > KW'(WINDOW_MAX)) begin
      k_eff = KW'(WINDOW_MAX);
    end
  end
  assign km1 = k_eff - 1'b1;

  // slot of the oldest sample in the window, modulo the line length
  assign diff      = {1'b0, slot_r} - {1'b0, km1[AW-1:0]};
  assign diff_wrap = diff + (AW+1)'(WINDOW_MAX);
  assign oldest    = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // delay line
  swa_ram #(
    .WIDTH (SB),
    .DEPTH (WINDOW_MAX)
  ) u_hist (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (slot_r),
    .wr_data (in_data.sample),
    .rd_en   (accept),
    .rd_addr (oldest),
    .rd_data (rd_data)
  );

  // fill count saturates at the line length
  assign fill_inc = (fill_r == FW'(WINDOW_MAX)) ? fill_r : (fill_r + 1'b1);

  // window of one: oldest sample is the one just written
  assign old_s = (k_eff == KW'(1)) ? s_r : rd_data;
  assign sum_w = run_r + {{(SW-SB){s_r[SB-1]}}, s_r};

  // hand-off to the divider
  assign job_valid      = (state_r == ST_SUM) && emit_r;
  assign job.window_sum = sum_w;
  assign job.last       = last_r;

  // control: accept, then update sum and dispatch
  always_comb begin
    state_nxt = state_r;
    run_nxt   = run_r;
    fill_nxt  = fill_r;
    slot_nxt  = slot_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          fill_nxt  = in_data.last ? '0 : fill_inc;
          slot_nxt  = (slot_r == AW'(WINDOW_MAX - 1)) ? '0 : (slot_r + 1'b1);
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (!emit_r || job_ready) begin
          if (last_r) begin
            run_nxt = '0;
          end else if (emit_r) begin
            run_nxt = sum_w - {{(SW-SB){old_s[SB-1]}}, old_s};
          end else begin
            run_nxt = sum_w;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= swa_pkg::WINDOW_LEN_RESET;
      run_r   <= '0;
      fill_r  <= '0;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      run_r   <= run_nxt;
      fill_r  <= fill_nxt;
      slot_r  <= slot_nxt;
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end
    end
    if (accept) begin
      s_r    <= in_data.sample;
      last_r <= in_data.last;
      emit_r <= (KW'(fill_inc) >= k_eff);
    end
  end

  // bit-serial divider
  swa_div #(
    .DIV_BITS (KW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .divisor   (k_eff),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

endmodule
